// ===== src/binary_to_decimal_ascii_defines.svh =====
// ---------------------------------------------------------------------------
// binary_to_decimal_ascii assertion macros
// Checks in the top level use these. They vanish when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef BINARY_TO_DECIMAL_ASCII_DEFINES_SVH
`define BINARY_TO_DECIMAL_ASCII_DEFINES_SVH

`ifndef SYNTHESIS
// Property that is checked at every clock edge, masked while in reset
`define B2DA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Same-cycle implication
`define B2DA_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define B2DA_ASSERT(label, prop, msg)
`define B2DA_ASSERT_IMPL(label, ante, cons, msg)
`endif

`endif

// ===== src/b2da_pkg.sv =====
// ---------------------------------------------------------------------------
// b2da_pkg
// Shared types and constants for the binary to decimal ASCII converter.
// ---------------------------------------------------------------------------
package b2da_pkg;

    // Default width of the converted number
    localparam int B2DA_VALUE_BITS = 64;

    // Fixed port widths
    localparam int VALUE_W = 64;
    localparam int CHAR_W  = 6;

    // ASCII code of '0', truncated to the character width
    localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

    // Operation of one BCD digit cell in a cycle
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_CLEAR,
        CELL_DABBLE,
        CELL_SHIFT
    } cell_mode_t;

    // Control word broadcast along the cell row
    typedef struct packed {
        cell_mode_t mode;
    } cell_ctrl_t;

endpackage

// ===== src/b2da_cell.sv =====
// ---------------------------------------------------------------------------
// b2da_cell
// One BCD digit of the shift-and-add-3 row. Takes a bit or a whole digit
// from its lower neighbor and hands its carry bit to its upper neighbor.
// ---------------------------------------------------------------------------
module b2da_cell (
    input  logic              clk,
    input  b2da_pkg::cell_ctrl_t ctrl,
    input  logic              bit_in,
    input  logic [3:0]        digit_in,
    output logic [3:0]        digit,
    output logic              carry_out
);
    import b2da_pkg::*;

    logic [3:0] digit_reg;
    logic [3:0] digit_next;
    logic [3:0] adj;

    // Add 3 when the digit would reach 10 or more after the shift
    always_comb
    begin
        adj = (digit_reg >= 4'd5) ? (digit_reg + 4'd3) : digit_reg;
    end

    always_comb
    begin
        case (ctrl.mode)
            CELL_HOLD:   digit_next = digit_reg;
            CELL_CLEAR:  digit_next = 4'd0;
            CELL_DABBLE: digit_next = {adj[2:0], bit_in};
            CELL_SHIFT:  digit_next = digit_in;
            default:     digit_next = digit_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        digit_reg <= digit_next;
    end

    assign digit     = digit_reg;
    assign carry_out = adj[3];

endmodule

// ===== src/binary_to_decimal_ascii.sv =====
// ---------------------------------------------------------------------------
// binary_to_decimal_ascii: unsigned binary word to decimal ASCII digit words
// The word is loaded, shifted bit by bit through the shift-and-add-3 row, then
// its NUM_DIGITS digit positions leave from the top, leading zeros skipped
// silently. The next word is taken once the last digit is registered, so
// output stalls delay it.
// Reset (rst_n low, async) returns to idle and drops the output word.
// ---------------------------------------------------------------------------
`include "binary_to_decimal_ascii_defines.svh"

module binary_to_decimal_ascii #(
    parameter int VALUE_BITS = b2da_pkg::B2DA_VALUE_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          value_valid,
    output logic                          value_stall,
    input  logic [b2da_pkg::VALUE_W-1:0]  value,
    output logic                          digit_valid,
    input  logic                          digit_stall,
    output logic [b2da_pkg::CHAR_W-1:0]   digit_char,
    output logic                          last
);
    import b2da_pkg::*;

    // Digits needed for the largest value: floor(bits * log10(2)) + 1
    localparam int NUM_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
    localparam int DIG_CNT_W  = $clog2(NUM_DIGITS + 1);
    localparam int BIT_CNT_W  = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CONV = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    state_t                  state_reg, state_next;
    logic [VALUE_BITS-1:0]   val_reg, val_next;
    logic [BIT_CNT_W-1:0]    bit_cnt_reg, bit_cnt_next;
    logic [DIG_CNT_W-1:0]    dig_cnt_reg, dig_cnt_next;
    logic                    started_reg, started_next;
    logic                    out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]       char_reg, char_next;
    logic                    last_reg, last_next;

    cell_ctrl_t              ctrl;
    logic [3:0]              dig   [NUM_DIGITS];
    logic                    carry [NUM_DIGITS];
    logic [3:0]              top_digit;
    logic                    out_free;
    logic                    skip_zero;

    // Row of BCD cells, cell 0 is the least significant digit
    for (genvar i = 0; i < NUM_DIGITS; i++)
    begin : g_cell
        if (i == 0)
        begin : g_low
            b2da_cell u_cell (
                .clk       (clk),
                .ctrl      (ctrl),
                .bit_in    (val_reg[VALUE_BITS-1]),
                .digit_in  (4'd0),
                .digit     (dig[i]),
                .carry_out (carry[i])
            );
        end
        else
        begin : g_upper
            b2da_cell u_cell (
                .clk       (clk),
                .ctrl      (ctrl),
                .bit_in    (carry[i-1]),
                .digit_in  (dig[i-1]),
                .digit     (dig[i]),
                .carry_out (carry[i])
            );
        end
    end

    assign top_digit = dig[NUM_DIGITS-1];
    assign out_free  = !out_valid_reg || !digit_stall;
    assign skip_zero = (top_digit == 4'd0) && !started_reg
                       && (dig_cnt_reg != DIG_CNT_W'(1));

    // Sequencer: load, shift-and-add-3, then shift digits out from the top
    always_comb
    begin
        state_next     = state_reg;
        val_next       = val_reg;
        bit_cnt_next   = bit_cnt_reg;
        dig_cnt_next   = dig_cnt_reg;
        started_next   = started_reg;
        out_valid_next = out_valid_reg && digit_stall;
        char_next      = char_reg;
        last_next      = last_reg;
        ctrl.mode      = CELL_HOLD;

        case (state_reg)
            ST_IDLE:
            begin
                if (value_valid)
                begin
                    val_next     = value[VALUE_BITS-1:0];
                    bit_cnt_next = BIT_CNT_W'(VALUE_BITS - 1);
                    ctrl.mode    = CELL_CLEAR;
                    state_next   = ST_CONV;
                end
            end
            ST_CONV:
            begin
                ctrl.mode    = CELL_DABBLE;
                val_next     = val_reg << 1;
                bit_cnt_next = bit_cnt_reg - BIT_CNT_W'(1);
                if (bit_cnt_reg == '0)
                begin
                    dig_cnt_next = DIG_CNT_W'(NUM_DIGITS);
                    started_next = 1'b0;
                    state_next   = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (skip_zero)
                begin
                    ctrl.mode    = CELL_SHIFT;
                    dig_cnt_next = dig_cnt_reg - DIG_CNT_W'(1);
                end
                else if (out_free)
                begin
                    ctrl.mode      = CELL_SHIFT;
                    dig_cnt_next   = dig_cnt_reg - DIG_CNT_W'(1);
                    started_next   = 1'b1;
                    out_valid_next = 1'b1;
                    char_next      = ASCII_ZERO | {2'b00, top_digit};
                    last_next      = (dig_cnt_reg == DIG_CNT_W'(1));
                    if (dig_cnt_reg == DIG_CNT_W'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            bit_cnt_reg   <= '0;
            dig_cnt_reg   <= '0;
            started_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bit_cnt_reg   <= bit_cnt_next;
            dig_cnt_reg   <= dig_cnt_next;
            started_reg   <= started_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        val_reg  <= val_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign value_stall = (state_reg != ST_IDLE);
    assign digit_valid = out_valid_reg;
    assign digit_char  = char_reg;
    assign last        = last_reg;

    // Checks
    `B2DA_ASSERT_IMPL(a_accept_starts_conv, value_valid && !value_stall,
        ##1 (state_reg == ST_CONV), "accepted word did not start conversion")
    `B2DA_ASSERT_IMPL(a_no_bcd_overflow, state_reg == ST_CONV, !carry[NUM_DIGITS-1],
        "BCD row overflowed its top digit")
    `B2DA_ASSERT_IMPL(a_emit_count_live, state_reg == ST_EMIT, dig_cnt_reg != '0,
        "digit count ran out while emitting")
    `B2DA_ASSERT_IMPL(a_char_is_digit, digit_valid,
        (digit_char[5:4] == 2'b11) && (digit_char[3:0] <= 4'd9),
        "output word is not a decimal digit")

endmodule

// ===== tb/digit_stream_checker.sv =====
// ---------------------------------------------------------------------------
// digit_stream_checker
// Watches both channels of the binary to decimal ASCII converter. Each
// accepted value is turned into its expected digit words. Each accepted
// digit word is compared against the oldest one still expected.
// ---------------------------------------------------------------------------
module digit_stream_checker #(
    parameter int VALUE_BITS = b2da_pkg::B2DA_VALUE_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          value_valid,
    input  logic                          value_stall,
    input  logic [b2da_pkg::VALUE_W-1:0]  value,
    input  logic                          digit_valid,
    input  logic                          digit_stall,
    input  logic [b2da_pkg::CHAR_W-1:0]   digit_char,
    input  logic                          last,
    input  logic                          end_of_run,
    output int                            errors,
    output int                            digits_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import b2da_pkg::*;

    localparam int MAX_DIGITS = 20;
    localparam logic [VALUE_W-1:0] VALUE_MASK =
        (VALUE_BITS >= VALUE_W) ? '1 : ({VALUE_W{1'b1}} >> (VALUE_W - VALUE_BITS));

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              is_last;
    } digit_word_t;

    digit_word_t expected_digits[$];
    int  mismatch_count   = 0;
    int  leftover_count   = 0;
    int  pending_count    = 0;
    bit  leftover_checked = 1'b0;

    assign errors         = mismatch_count + leftover_count;
    assign digits_pending = pending_count;

    // Split a number into decimal digits, most significant first, no leading zeros
    function automatic void queue_decimal_digits(input logic [VALUE_W-1:0] number);
        logic [VALUE_W-1:0] rest;
        logic [3:0]         rev_digits [MAX_DIGITS];
        int                 count;
        rest  = number & VALUE_MASK;
        count = 0;
        do
        begin
            rev_digits[count] = 4'(rest % 10);
            rest = rest / 10;
            count++;
        end
        while (rest != 0 && count < MAX_DIGITS);
        for (int k = count - 1; k >= 0; k--)
        begin
            expected_digits.push_back('{code: ASCII_ZERO + CHAR_W'(rev_digits[k]),
                                        is_last: (k == 0)});
        end
    endfunction

    // Compare accepted digit words, then queue expectations of accepted values
    always @(posedge clk or negedge rst_n)
    begin : watch_channels
        digit_word_t want;
        if (!rst_n)
        begin
            expected_digits.delete();
            pending_count = 0;
        end
        else
        begin
            if (digit_valid && !digit_stall)
            begin
                if (expected_digits.size() == 0)
                begin
                    $error("unexpected digit word: digit_char %0d last %0b", digit_char, last);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_digits.pop_front();
                    if (digit_char !== want.code)
                    begin
                        $error("digit_char: expected %0d, actual %0d", want.code, digit_char);
                        mismatch_count++;
                    end
                    if (last !== want.is_last)
                    begin
                        $error("last: expected %0b, actual %0b", want.is_last, last);
                        mismatch_count++;
                    end
                end
            end

            if (value_valid && !value_stall)
                queue_decimal_digits(value);

            // Anything still queued at the end never showed up
            if (end_of_run && !leftover_checked)
            begin
                leftover_checked = 1'b1;
                if (expected_digits.size() != 0)
                begin
                    $error("%0d expected digit words never arrived", expected_digits.size());
                    leftover_count = expected_digits.size();
                end
            end

            pending_count = expected_digits.size();
        end
    end

endmodule

// ===== tb/tb_top.sv =====
// ---------------------------------------------------------------------------
// tb_top
// Drives 64-bit values into the binary to decimal ASCII converter: a
// directed set of edge values, then random values spread over all digit
// counts, with random idle cycles on both sides and a long receiver hold-off.
// The checker module does all prediction and comparison.
// ---------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import b2da_pkg::*;

    localparam int VALUE_BITS       = B2DA_VALUE_BITS;
    localparam int HALF_PERIOD      = 5;
    localparam int RESET_CYCLES     = 5;
    localparam int MAX_GAP          = 16;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int RANDOM_ITEMS     = 130;
    localparam int PHASE_ITEMS      = 25;
    localparam int DRAIN_LIMIT      = 5000;
    localparam int SETTLE_CYCLES    = 120;
    localparam int LIMIT_NS         = 4_000_000;

    logic               clk         = 1'b0;
    logic               rst_n       = 1'b0;
    logic               value_valid = 1'b0;
    logic [VALUE_W-1:0] value       = '0;
    logic               digit_stall = 1'b0;
    logic               end_of_run  = 1'b0;
    logic               value_stall;
    logic               digit_valid;
    logic [CHAR_W-1:0]  digit_char;
    logic               last;
    int                 errors;
    int                 digits_pending;

    bit send_idle_on  = 1'b0;
    bit recv_idle_on  = 1'b0;
    bit long_hold_req = 1'b0;

    always #HALF_PERIOD clk = ~clk;

    binary_to_decimal_ascii #(
        .VALUE_BITS (VALUE_BITS)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .value_valid (value_valid),
        .value_stall (value_stall),
        .value       (value),
        .digit_valid (digit_valid),
        .digit_stall (digit_stall),
        .digit_char  (digit_char),
        .last        (last)
    );

    digit_stream_checker #(
        .VALUE_BITS (VALUE_BITS)
    ) u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .value_valid    (value_valid),
        .value_stall    (value_stall),
        .value          (value),
        .digit_valid    (digit_valid),
        .digit_stall    (digit_stall),
        .digit_char     (digit_char),
        .last           (last),
        .end_of_run     (end_of_run),
        .errors         (errors),
        .digits_pending (digits_pending)
    );

    function automatic int draw_gap(input bit enabled);
        return enabled ? int'($urandom_range(0, MAX_GAP)) : 0;
    endfunction

    function automatic logic [VALUE_W-1:0] power_of_ten(input int exponent);
        logic [VALUE_W-1:0] p;
        p = VALUE_W'(1);
        repeat (exponent) p = p * 10;
        return p;
    endfunction

    // Offer one word at a falling edge and hold it until taken
    task automatic send_word(input logic [VALUE_W-1:0] number);
        int gap;
        gap = draw_gap(send_idle_on);
        if (gap > 0)
        begin
            value_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        value       <= number;
        value_valid <= 1'b1;
        do
            @(posedge clk);
        while (!(value_valid && !value_stall));
        @(negedge clk);
    endtask

    // Receiver: random stall before each digit word, one long hold-off on request
    initial
    begin : digit_receiver
        int gap;
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                gap = LONG_HOLD_CYCLES;
                long_hold_req = 1'b0;
            end
            else
            begin
                gap = draw_gap(recv_idle_on);
            end
            if (gap > 0)
            begin
                digit_stall <= 1'b1;
                repeat (gap) @(negedge clk);
            end
            digit_stall <= 1'b0;
            do
                @(posedge clk);
            while (!(digit_valid && !digit_stall));
        end
    end

    // Hard limit on the whole run
    initial
    begin : run_limit
        #LIMIT_NS;
        $display("status: fail");
        $finish;
    end

    initial
    begin : stimulus
        logic [VALUE_W-1:0] directed_words [20];
        logic [VALUE_W-1:0] random_word;
        logic [VALUE_W-1:0] full_word;

        directed_words = '{
            64'd0, 64'd1, 64'd9, 64'd10, 64'd99, 64'd100, 64'd101,
            64'd999999999, 64'd1000000000, 64'd4294967295, 64'd4294967296,
            64'h0000_0000_0000_00FF, 64'hFF00_0000_0000_0000,
            64'h8000_0000_0000_0000, 64'hAAAA_AAAA_AAAA_AAAA,
            64'h5555_5555_5555_5555, 64'd9999999999999999999,
            64'd10000000000000000000, 64'd12345678901234567890,
            64'hFFFF_FFFF_FFFF_FFFF
        };

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Edge values: back to back first, then with receiver gaps
        foreach (directed_words[i])
        begin
            recv_idle_on = (i >= 10);
            send_word(directed_words[i]);
        end

        // Sender pauses until every expected digit has come out
        value_valid <= 1'b0;
        wait (digits_pending == 0);
        @(negedge clk);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % PHASE_ITEMS == 0)
            begin
                send_idle_on = 1'($urandom_range(0, 1));
                recv_idle_on = 1'($urandom_range(0, 1));
                // Long receiver hold-off while the sender keeps pushing
                if (i == 2 * PHASE_ITEMS)
                begin
                    send_idle_on  = 1'b0;
                    long_hold_req = 1'b1;
                end
            end

            full_word = {$urandom(), $urandom()};
            case ($urandom_range(0, 3))
                0: random_word = full_word;
                1: random_word = full_word >> $urandom_range(0, VALUE_W - 1);
                2: random_word = power_of_ten($urandom_range(0, 19))
                                 + VALUE_W'($urandom_range(0, 2)) - 1;
                default: random_word = {VALUE_W{1'b1}} >> $urandom_range(0, VALUE_W - 1);
            endcase
            send_word(random_word);
        end
        value_valid <= 1'b0;

        // Drain: wait for outstanding digits, then let the block settle
        for (int c = 0; c < DRAIN_LIMIT && digits_pending != 0; c++)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        end_of_run <= 1'b1;
        @(negedge clk);

        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
